>>> design/pwld_pkg.sv
// Shared types, constants and helpers of the pulse width line decoder.
// Depends on nothing; every other design file imports it.
package pwld_pkg;

   localparam int ROW_WORDS    = 40;
   localparam int COLUMN_COUNT = 240;
   localparam int ROW_FILL     = ROW_WORDS * 16;

   localparam int GAP_W   = 16;
   localparam int FILL_W  = 10;
   localparam int COL_W   = 8;
   localparam int SLOT_W  = $clog2(ROW_WORDS);
   localparam int WORD_W  = 32;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [WORD_W-1:0] END_MARKER = 32'h1234_5678;

   localparam logic [GAP_W-1:0]  SYNC_LOW_RST  = 16'd4350;
   localparam logic [GAP_W-1:0]  SYNC_HIGH_RST = 16'd4550;
   localparam logic [GAP_W-1:0]  ZERO_LOW_RST  = 16'd400;
   localparam logic [GAP_W-1:0]  ZERO_HIGH_RST = 16'd700;
   localparam logic [GAP_W-1:0]  ONE_LOW_RST   = 16'd1500;
   localparam logic [GAP_W-1:0]  ONE_HIGH_RST  = 16'd1900;
   localparam logic [FILL_W-1:0] END_MIN_RST   = 10'd320;

   typedef enum logic [2:0] {
      REG_SYNC_LOW  = 3'd0,
      REG_SYNC_HIGH = 3'd1,
      REG_ZERO_LOW  = 3'd2,
      REG_ZERO_HIGH = 3'd3,
      REG_ONE_LOW   = 3'd4,
      REG_ONE_HIGH  = 3'd5,
      REG_END_MIN   = 3'd6
   } pwld_reg_type;

   typedef struct packed {
      logic [GAP_W-1:0]  sync_low;
      logic [GAP_W-1:0]  sync_high;
      logic [GAP_W-1:0]  zero_low;
      logic [GAP_W-1:0]  zero_high;
      logic [GAP_W-1:0]  one_low;
      logic [GAP_W-1:0]  one_high;
      logic [FILL_W-1:0] end_min_pixels;
   } pwld_cfg_type;

   // Column counter step with wrap at the display width.
   function automatic logic [COL_W-1:0] next_column(input logic [COL_W-1:0] c);
      logic [COL_W:0] s;
      s = {1'b0, c} + {{COL_W{1'b0}}, 1'b1};
      if (s >= (COL_W+1)'(COLUMN_COUNT)) begin
         return '0;
      end
      return s[COL_W-1:0];
   endfunction

endpackage

>>> design/pwld_if.sv
// Valid/ready channel interfaces for edge items and row results.
// Depends on pwld_pkg for field widths.
interface pwld_req_if import pwld_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             line_level;
   logic [GAP_W-1:0] gap_us;

   modport source (output valid, output line_level, output gap_us, input ready);
   modport sink   (input valid, input line_level, input gap_us, output ready);
endinterface

interface pwld_rsp_if import pwld_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  column;
   logic [5:0]        word_slot;
   logic [WORD_W-1:0] pixel_bytes;
   logic              last;

   modport source (output valid, output column, output word_slot,
                    output pixel_bytes, output last, input ready);
   modport sink   (input valid, input column, input word_slot,
                   input pixel_bytes, input last, output ready);
endinterface

>>> design/pwld_csr.sv
// APB-style register file holding the timing windows and the end threshold.
// Depends on pwld_pkg for the register map and the configuration struct.
module pwld_csr import pwld_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output pwld_cfg_type      cfg
);

   pwld_cfg_type cfg_ff, cfg_in;
   pwld_reg_type reg_sel;
   logic         wr_en;

   assign pready  = 1'b1;
   assign reg_sel = pwld_reg_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SYNC_LOW:  cfg_in.sync_low       = pwdata[GAP_W-1:0];
            REG_SYNC_HIGH: cfg_in.sync_high      = pwdata[GAP_W-1:0];
            REG_ZERO_LOW:  cfg_in.zero_low       = pwdata[GAP_W-1:0];
            REG_ZERO_HIGH: cfg_in.zero_high      = pwdata[GAP_W-1:0];
            REG_ONE_LOW:   cfg_in.one_low        = pwdata[GAP_W-1:0];
            REG_ONE_HIGH:  cfg_in.one_high       = pwdata[GAP_W-1:0];
            REG_END_MIN:   cfg_in.end_min_pixels = pwdata[FILL_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SYNC_LOW:  prdata = DATA_W'(cfg_ff.sync_low);
         REG_SYNC_HIGH: prdata = DATA_W'(cfg_ff.sync_high);
         REG_ZERO_LOW:  prdata = DATA_W'(cfg_ff.zero_low);
         REG_ZERO_HIGH: prdata = DATA_W'(cfg_ff.zero_high);
         REG_ONE_LOW:   prdata = DATA_W'(cfg_ff.one_low);
         REG_ONE_HIGH:  prdata = DATA_W'(cfg_ff.one_high);
         REG_END_MIN:   prdata = DATA_W'(cfg_ff.end_min_pixels);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_low       <= SYNC_LOW_RST;
         cfg_ff.sync_high      <= SYNC_HIGH_RST;
         cfg_ff.zero_low       <= ZERO_LOW_RST;
         cfg_ff.zero_high      <= ZERO_HIGH_RST;
         cfg_ff.one_low        <= ONE_LOW_RST;
         cfg_ff.one_high       <= ONE_HIGH_RST;
         cfg_ff.end_min_pixels <= END_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/pulse_width_line_decoder_core.sv
// Pulse width line decoder: an edge item is taken while the core is idle; a row-ending edge
// is followed by 40 results, the first reaching valid through the state, memory data and output registers,
// then one per cycle while the sink keeps ready high, paced by the row memory read port.
// No edge is taken until the last group has been read from the row memory.
// Reset is synchronous and clears the decoder, column and output control state;
// the row memory is not cleared and only groups filled in the current row are read back.
module pulse_width_line_decoder_core import pwld_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pwld_req_if.sink          req,
   pwld_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   pwld_cfg_type cfg;

   pwld_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Row memory: one write port from the decoder, one registered read port.
   logic [WORD_W-1:0] row_mem [ROW_WORDS];

   state_type         state_ff, state_in;
   logic              frame_ff, frame_in;
   logic [4:0]        bit_pos_ff, bit_pos_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  emit_col_ff, emit_col_in;
   logic [SLOT_W:0]   emit_used_ff, emit_used_in;
   logic [SLOT_W:0]   issue_cnt_ff, issue_cnt_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [WORD_W-1:0] mem_q_ff;
   logic              out_valid_ff, out_valid_in;
   logic [COL_W-1:0]  out_col_ff;
   logic [SLOT_W-1:0] out_slot_ff;
   logic [WORD_W-1:0] out_data_ff;
   logic              out_last_ff;

   logic              accept;
   logic              is_sync;
   logic              is_zero;
   logic              is_one;
   logic [WORD_W-1:0] bit_mask;
   logic [WORD_W-1:0] word_new;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic              issue;
   logic              out_load;
   logic [COL_W-1:0]  col_step;

   assign req.ready       = (state_ff == ST_IDLE);
   assign accept          = req.valid && req.ready;
   assign rsp.valid       = out_valid_ff;
   assign rsp.column      = out_col_ff;
   assign rsp.word_slot   = 6'(out_slot_ff);
   assign rsp.pixel_bytes = out_data_ff;
   assign rsp.last        = out_last_ff;

   assign is_sync = !req.line_level && (req.gap_us > cfg.sync_low)
                    && (req.gap_us < cfg.sync_high);
   assign is_zero = (req.gap_us > cfg.zero_low) && (req.gap_us < cfg.zero_high);
   assign is_one  = (req.gap_us > cfg.one_low) && (req.gap_us < cfg.one_high);
   assign bit_mask = {1'b1, {(WORD_W-1){1'b0}}} >> bit_pos_ff;
   assign wr_addr  = fill_ff[4 +: SLOT_W];
   assign col_step = next_column(col_ff);

   always_comb begin
      if (is_zero) begin
         word_new = shift_ff & ~bit_mask;
      end else if (is_one) begin
         word_new = shift_ff | bit_mask;
      end else begin
         word_new = shift_ff;
      end
   end

   // Read-out pipeline: a read is issued when the memory data register is free
   // or moves into the output register in the same cycle.
   assign out_load = pend_ff && (!out_valid_ff || rsp.ready);
   assign issue    = (state_ff == ST_EMIT)
                     && (issue_cnt_ff < (SLOT_W+1)'(ROW_WORDS))
                     && (!pend_ff || out_load);

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      bit_pos_in   = bit_pos_ff;
      shift_in     = shift_ff;
      fill_in      = fill_ff;
      col_in       = col_ff;
      emit_col_in  = emit_col_ff;
      emit_used_in = emit_used_ff;
      issue_cnt_in = issue_cnt_ff;
      wr_en        = 1'b0;

      if (accept) begin
         if (is_sync) begin
            frame_in   = 1'b1;
            bit_pos_in = '0;
         end else if (frame_ff && !req.line_level) begin
            bit_pos_in = bit_pos_ff + 5'd1;
            shift_in   = word_new;
            if (bit_pos_ff == 5'd31) begin
               frame_in = 1'b0;
               if (((word_new == END_MARKER) && (fill_ff > cfg.end_min_pixels))
                   || (fill_ff >= FILL_W'(ROW_FILL))) begin
                  // Row end: the column steps once before and once after the row.
                  state_in     = ST_EMIT;
                  emit_col_in  = col_step;
                  col_in       = next_column(col_step);
                  emit_used_in = (SLOT_W+1)'(fill_ff[FILL_W-1:4]);
                  issue_cnt_in = '0;
                  shift_in     = '0;
                  fill_in      = '0;
               end else if (word_new == END_MARKER) begin
                  fill_in = '0;
               end else begin
                  wr_en    = 1'b1;
                  fill_in  = fill_ff + FILL_W'(16);
                  shift_in = '0;
               end
            end
         end
      end

      if (issue) begin
         issue_cnt_in = issue_cnt_ff + (SLOT_W+1)'(1);
      end
      if ((state_ff == ST_EMIT) && (issue_cnt_ff == (SLOT_W+1)'(ROW_WORDS)) && !pend_ff) begin
         state_in = ST_IDLE;
      end

      pend_in = issue || (pend_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= word_new;
      end
      if (issue) begin
         mem_q_ff     <= row_mem[issue_cnt_ff[SLOT_W-1:0]];
         pend_slot_ff <= issue_cnt_ff[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= 1'b0;
         bit_pos_ff   <= '0;
         shift_ff     <= '0;
         fill_ff      <= '0;
         col_ff       <= '0;
         emit_col_ff  <= '0;
         emit_used_ff <= '0;
         issue_cnt_ff <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         bit_pos_ff   <= bit_pos_in;
         shift_ff     <= shift_in;
         fill_ff      <= fill_in;
         col_ff       <= col_in;
         emit_col_ff  <= emit_col_in;
         emit_used_ff <= emit_used_in;
         issue_cnt_ff <= issue_cnt_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      // Groups beyond the filled part of the row go out as zero.
      if (out_load) begin
         out_col_ff  <= emit_col_ff;
         out_slot_ff <= pend_slot_ff;
         out_data_ff <= ((SLOT_W+1)'(pend_slot_ff) < emit_used_ff) ? mem_q_ff : '0;
         out_last_ff <= (pend_slot_ff == SLOT_W'(ROW_WORDS - 1));
      end
   end

endmodule

>>> test/tb_pulse_width_line_decoder_core.sv
// Self-checking testbench for pulse_width_line_decoder_core: edge stimulus, APB register
// programming, an in-bench row decoder that predicts every emitted group, and a checker.
// Depends on pwld_pkg, the pwld_req_if / pwld_rsp_if channel interfaces and the core.
module tb_pulse_width_line_decoder_core;
   import pwld_pkg::*;

   typedef struct {
      logic             level;
      logic [GAP_W-1:0] gap;
      bit               drain;
   } line_edge_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [5:0]        word_slot;
      logic [WORD_W-1:0] pixel_bytes;
      logic              last;
   } row_group_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   pwld_req_if req_ch ();
   pwld_rsp_if rsp_ch ();

   pulse_width_line_decoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   // Register copy and decoder state of the prediction.
   pwld_cfg_type      cfg;
   logic              dec_frame;
   int                dec_bit;
   logic [WORD_W-1:0] dec_word;
   logic [FILL_W-1:0] dec_fill;
   logic [COL_W-1:0]  dec_column;
   logic [WORD_W-1:0] row_copy [ROW_WORDS];
   int                rows_emitted = 0;

   line_edge_type pending_edges[$];
   row_group_type row_results[$];
   line_edge_type in_flight;
   int         edges_sent = 0;
   int         edges_done = 0;
   int         noise_pct = 0;
   int         fails = 0;
   int         mismatches = 0;
   int         send_wait = 0;
   int         send_calm = 0;
   int         take_wait = 0;
   int         take_calm = 0;
   int         hold_left = 0;
   int         holds_done = 0;

   function automatic logic [COL_W-1:0] step_column(input logic [COL_W-1:0] c);
      if (int'(c) + 1 >= COLUMN_COUNT) begin
         return '0;
      end
      return c + 1'b1;
   endfunction

   task automatic decode_edge(input logic level, input logic [GAP_W-1:0] gap);
      logic [WORD_W-1:0] mask;
      row_group_type     g;
      int                used;
      if (!level && gap > cfg.sync_low && gap < cfg.sync_high) begin
         dec_frame = 1'b1;
         dec_bit = 0;
         return;
      end
      if (!dec_frame || level) begin
         return;
      end
      mask = 32'h1 << (31 - dec_bit);
      if (gap > cfg.zero_low && gap < cfg.zero_high) begin
         dec_word &= ~mask;
      end else if (gap > cfg.one_low && gap < cfg.one_high) begin
         dec_word |= mask;
      end
      dec_bit++;
      if (dec_bit < 32) begin
         return;
      end
      dec_frame = 1'b0;
      dec_bit = 0;
      if ((dec_word == END_MARKER && dec_fill > cfg.end_min_pixels) ||
          int'(dec_fill) >= ROW_FILL) begin
         // The completing word is dropped; the row goes out one column on.
         used = int'(dec_fill) / 16;
         dec_column = step_column(dec_column);
         for (int k = 0; k < ROW_WORDS; k++) begin
            g.column = dec_column;
            g.word_slot = 6'(k);
            g.pixel_bytes = (k < used) ? row_copy[k] : '0;
            g.last = (k == ROW_WORDS - 1);
            row_results.push_back(g);
         end
         dec_column = step_column(dec_column);
         dec_word = '0;
         dec_fill = '0;
         rows_emitted++;
      end else if (dec_word == END_MARKER) begin
         dec_fill = '0;
      end else begin
         row_copy[int'(dec_fill) / 16] = dec_word;
         dec_fill = dec_fill + FILL_W'(16);
         dec_word = '0;
      end
   endtask

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   // Edge source: one offer at a time, predicted when its transfer completes.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decode_edge(in_flight.level, in_flight.gap);
            edges_done++;
            send_wait = draw_wait(send_calm);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // Offer stays up until the core takes it.
         end else if (send_wait > 0) begin
            send_wait--;
            req_ch.valid <= 1'b0;
         end else if (pending_edges.size() > 0 &&
                      !(pending_edges[0].drain && row_results.size() > 0)) begin
            in_flight = pending_edges.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.line_level <= in_flight.level;
            req_ch.gap_us <= in_flight.gap;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-offs, at most two, each started once a full row is waiting.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && row_results.size() >= ROW_WORDS &&
                   rows_emitted >= (holds_done == 0 ? 1 : 2)) begin
         hold_left <= 400;
         holds_done++;
      end
   end

   task automatic report_fault(input string what);
      fails++;
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", what);
      end
   endtask

   // Result sink and checker.
   always @(posedge clock) begin
      row_group_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (row_results.size() == 0) begin
               report_fault($sformatf("unexpected group: column %0d slot %0d data %h last %b",
                  rsp_ch.column, rsp_ch.word_slot, rsp_ch.pixel_bytes, rsp_ch.last));
            end else begin
               want = row_results.pop_front();
               if (rsp_ch.column !== want.column || rsp_ch.word_slot !== want.word_slot ||
                   rsp_ch.pixel_bytes !== want.pixel_bytes || rsp_ch.last !== want.last) begin
                  report_fault($sformatf(
                     "group mismatch: want col %0d slot %0d data %h last %b, got %0d %0d %h %b",
                     want.column, want.word_slot, want.pixel_bytes, want.last,
                     rsp_ch.column, rsp_ch.word_slot, rsp_ch.pixel_bytes, rsp_ch.last));
               end
            end
            take_wait = draw_wait(take_calm);
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input pwld_reg_type r, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (r)
         REG_SYNC_LOW:  cfg.sync_low = value[GAP_W-1:0];
         REG_SYNC_HIGH: cfg.sync_high = value[GAP_W-1:0];
         REG_ZERO_LOW:  cfg.zero_low = value[GAP_W-1:0];
         REG_ZERO_HIGH: cfg.zero_high = value[GAP_W-1:0];
         REG_ONE_LOW:   cfg.one_low = value[GAP_W-1:0];
         REG_ONE_HIGH:  cfg.one_high = value[GAP_W-1:0];
         REG_END_MIN:   cfg.end_min_pixels = value[FILL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_windows(input int sl, input int sh, input int zl, input int zh,
                                  input int ol, input int oh, input int em);
      csr_write(REG_SYNC_LOW, sl);
      csr_write(REG_SYNC_HIGH, sh);
      csr_write(REG_ZERO_LOW, zl);
      csr_write(REG_ZERO_HIGH, zh);
      csr_write(REG_ONE_LOW, ol);
      csr_write(REG_ONE_HIGH, oh);
      csr_write(REG_END_MIN, em);
   endtask

   // Disjoint random windows, zero below one below sync.
   task automatic program_random_windows(input int em);
      int zl, zh, ol, oh, sl, sh;
      zl = $urandom_range(0, 2000);
      zh = zl + $urandom_range(2, 800);
      ol = zh + $urandom_range(0, 500);
      oh = ol + $urandom_range(2, 800);
      sl = oh + $urandom_range(0, 1000);
      sh = sl + $urandom_range(2, 3000);
      program_windows(sl, sh, zl, zh, ol, oh, em);
   endtask

   function automatic logic [GAP_W-1:0] pick_in(input logic [GAP_W-1:0] lo,
                                                input logic [GAP_W-1:0] hi);
      if (int'(hi) < int'(lo) + 2) begin
         return lo;
      end
      return GAP_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
   endfunction

   task automatic push_edge(input logic level, input logic [GAP_W-1:0] gap,
                            input bit drain = 1'b0);
      line_edge_type e;
      e.level = level;
      e.gap = gap;
      e.drain = drain;
      pending_edges.push_back(e);
      edges_sent++;
   endtask

   task automatic push_noise();
      push_edge(1'(($urandom_range(0, 1))), GAP_W'($urandom_range(0, 65535)));
   endtask

   task automatic push_bit(input logic b);
      if ($urandom_range(0, 99) < noise_pct) begin
         push_edge(1'b1, GAP_W'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 99) < noise_pct) begin
         push_noise();
      end
      push_edge(1'b0, b ? pick_in(cfg.one_low, cfg.one_high)
                        : pick_in(cfg.zero_low, cfg.zero_high));
   endtask

   task automatic push_word(input logic [WORD_W-1:0] w, input bit drain);
      push_edge(1'b0, pick_in(cfg.sync_low, cfg.sync_high), drain);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         push_bit(w[i]);
      end
   endtask

   task automatic push_row(input int words, input bit drain);
      for (int i = 0; i < words; i++) begin
         push_word($urandom(), drain && i == 0);
      end
      push_word(END_MARKER, 1'b0);
   endtask

   task automatic wait_quiet();
      while (edges_done != edges_sent || row_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.line_level = 1'b0;
      req_ch.gap_us = '0;
      rsp_ch.ready = 1'b0;
      cfg.sync_low = SYNC_LOW_RST;
      cfg.sync_high = SYNC_HIGH_RST;
      cfg.zero_low = ZERO_LOW_RST;
      cfg.zero_high = ZERO_HIGH_RST;
      cfg.one_low = ONE_LOW_RST;
      cfg.one_high = ONE_HIGH_RST;
      cfg.end_min_pixels = END_MIN_RST;
      dec_frame = 1'b0;
      dec_bit = 0;
      dec_word = '0;
      dec_fill = '0;
      dec_column = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edges at the reset windows: idle extremes, sync window borders,
      // a rising edge inside the sync window, bit windows, and a resync mid word.
      push_edge(1'b1, 16'd0);
      push_edge(1'b0, 16'hFFFF);
      push_edge(1'b0, 16'd4350);
      push_edge(1'b0, 16'd4550);
      push_edge(1'b1, 16'd4400);
      push_edge(1'b0, 16'd4351);
      push_edge(1'b0, 16'd401);
      push_edge(1'b0, 16'd1899);
      push_edge(1'b0, 16'd700);
      push_edge(1'b0, 16'd4549);
      wait_quiet();

      // Random windows; a marker ends a row after one group. The long hold-off on
      // the first row stalls the edges of the second row, and the tail waits
      // until every group of the second row has come back.
      program_random_windows(0);
      push_row(1, 1'b0);
      noise_pct = 2;
      push_row(1, 1'b0);
      push_edge(1'b0, 16'd0, 1'b1);
      push_noise();
      push_noise();
      wait_quiet();
      repeat (20) @(posedge clock);

      if (row_results.size() != 0) begin
         $display("%0d expected groups never arrived", row_results.size());
         fails++;
      end
      if (fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> pulse_width_line_decoder_core.f
design/pwld_pkg.sv
design/pwld_if.sv
design/pwld_csr.sv
design/pulse_width_line_decoder_core.sv
test/tb_pulse_width_line_decoder_core.sv
